// ----- design/ffba_pkg.sv -----
package ffba_pkg;

  localparam int unsigned LEN_W   = 9;
  localparam int unsigned CFG_A_W = 8;

  localparam logic [CFG_A_W-1:0] CFG_POOL_BASE   = 8'd0;
  localparam logic [CFG_A_W-1:0] CFG_BLOCK_SHIFT = 8'd1;

  localparam logic [4:0] BLOCK_SHIFT_RST = 5'd12;

  typedef struct packed {
    logic [LEN_W-1:0] blocks_needed;
    logic [31:0]      request_bytes;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  start_block;
    logic [31:0] address;
  } rsp_t;

  typedef struct packed {
    logic             busy;
    logic             head;
    logic [LEN_W-1:0] len;
  } blk_info_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear_wr;
    logic load_req;
    logic scan_start;
    logic scan_en;
    logic mark_wr;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_zero;
    logic hit;
    logic scan_last;
    logic mark_last;
    logic out_full;
  } ctrl_status_t;

endpackage

// ----- design/ffba_ctrl.sv -----
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  logic         rsp_ready_i,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o,
  output logic         req_ready_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (status_i.req_zero) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.hit) begin
          state_d = ST_MARK;
        end else if (status_i.scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_MARK: begin
        cmd_o.mark_wr = 1'b1;
        if (status_i.mark_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait until the previous result has been taken
        if (!status_i.out_full || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/ffba_datapath.sv -----
module ffba_datapath
  import ffba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_status_t       status_o,
  input  req_t               req_i,
  input  logic               rsp_ready_i,
  output logic               rsp_valid_o,
  output rsp_t               rsp_o,
  input  logic               cfg_valid_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned IW = $clog2(NUM_BLOCKS);

  // configuration
  logic [31:0] pool_base_q;
  logic [4:0]  block_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= '0;
      block_shift_q <= BLOCK_SHIFT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_POOL_BASE) begin
        pool_base_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_BLOCK_SHIFT) begin
        block_shift_q <= cfg_data_i[4:0];
      end
    end
  end

  // block state memories
  blk_info_t   info_mem [NUM_BLOCKS];
  logic [31:0] size_mem [NUM_BLOCKS];
  blk_info_t   info_rdata_q;

  logic [LEN_W-1:0] need_q;
  logic [31:0]      bytes_q;
  logic [IW-1:0]    clr_cnt_q;
  logic [IW:0]      scan_cnt_q;
  logic             rvalid_q;
  logic [IW-1:0]    eval_idx_q;
  logic [LEN_W-1:0] run_cnt_q, run_cnt_d;
  logic [IW-1:0]    start_q, start_d;
  logic             found_q, found_d;
  logic [LEN_W-1:0] mark_cnt_q;
  logic             out_valid_q;
  rsp_t             rsp_q;

  logic             issue;
  logic             blk_free;
  logic             hit;
  logic [IW-1:0]    mark_addr;
  logic [IW-1:0]    wr_addr;
  logic             wr_en;
  blk_info_t        wr_info;
  logic             size_wr;
  logic [31:0]      size_wdata;
  logic [31:0]      start_ext;
  logic [31:0]      address;

  assign mark_addr = start_q + IW'(mark_cnt_q);

  always_comb begin
    wr_en      = cmd_i.clear_wr | cmd_i.mark_wr;
    wr_addr    = cmd_i.clear_wr ? clr_cnt_q : mark_addr;
    wr_info    = '0;
    size_wr    = cmd_i.clear_wr;
    size_wdata = '0;
    if (cmd_i.mark_wr) begin
      wr_info.busy = 1'b1;
      wr_info.head = (mark_cnt_q == '0);
      wr_info.len  = need_q;
      size_wr      = (mark_cnt_q == '0);
      size_wdata   = bytes_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      info_mem[wr_addr] <= wr_info;
    end
    if (size_wr) begin
      size_mem[wr_addr] <= size_wdata;
    end
  end

  assign issue = cmd_i.scan_en && (scan_cnt_q < (IW+1)'(NUM_BLOCKS));

  always_ff @(posedge clk_i) begin
    if (issue) begin
      info_rdata_q <= info_mem[scan_cnt_q[IW-1:0]];
    end
  end

  // first-fit run tracking on the returned busy bits
  assign blk_free = !info_rdata_q.busy;
  assign hit      = cmd_i.scan_en && rvalid_q && blk_free && (run_cnt_q + 9'd1 == need_q);

  always_comb begin
    run_cnt_d = run_cnt_q;
    start_d   = start_q;
    found_d   = found_q;
    if (cmd_i.load_req) begin
      run_cnt_d = '0;
      start_d   = '0;
      found_d   = 1'b0;
    end else if (cmd_i.scan_en && rvalid_q) begin
      if (!blk_free) begin
        run_cnt_d = '0;
      end else begin
        if (run_cnt_q == '0) begin
          start_d = eval_idx_q;
        end
        run_cnt_d = run_cnt_q + 9'd1;
        if (hit) begin
          found_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      scan_cnt_q  <= '0;
      rvalid_q    <= 1'b0;
      run_cnt_q   <= '0;
      start_q     <= '0;
      found_q     <= 1'b0;
      mark_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) begin
        clr_cnt_q <= clr_cnt_q + IW'(1);
      end
      if (cmd_i.scan_start) begin
        scan_cnt_q <= '0;
        rvalid_q   <= 1'b0;
        mark_cnt_q <= '0;
      end else begin
        if (issue) begin
          scan_cnt_q <= scan_cnt_q + (IW+1)'(1);
        end
        rvalid_q <= issue;
        if (cmd_i.mark_wr) begin
          mark_cnt_q <= mark_cnt_q + 9'd1;
        end
      end
      run_cnt_q <= run_cnt_d;
      start_q   <= start_d;
      found_q   <= found_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      need_q  <= req_i.blocks_needed;
      bytes_q <= req_i.request_bytes;
    end
    if (issue) begin
      eval_idx_q <= scan_cnt_q[IW-1:0];
    end
  end

  // byte address of the run, wraps at 32 bits
  assign start_ext = 32'(start_q);
  assign address   = pool_base_q + (start_ext << block_shift_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rsp_q.found       <= found_q;
      rsp_q.start_block <= found_q ? start_ext[7:0] : 8'd0;
      rsp_q.address     <= found_q ? address : 32'd0;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  assign status_o.clear_last = (clr_cnt_q == IW'(NUM_BLOCKS - 1));
  assign status_o.req_zero   = (req_i.blocks_needed == '0);
  assign status_o.hit        = hit;
  assign status_o.scan_last  = rvalid_q && (eval_idx_q == IW'(NUM_BLOCKS - 1));
  assign status_o.mark_last  = (mark_cnt_q == need_q - 9'd1);
  assign status_o.out_full   = out_valid_q;

endmodule

// ----- design/first_fit_block_allocator.sv -----
// channel  direction  handshake                payload
// req      in         req_valid_i/req_ready_o  req_i (blocks_needed, request_bytes)
// rsp      out        rsp_valid_o/rsp_ready_i  rsp_o (found, start_block, address)
// cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// one request at a time: the busy map is read one block per cycle through a single
// registered read port, so a request scans up to NUM_BLOCKS blocks and, if a fitting
// run is found, then marks its blocks_needed blocks.
// after reset a clearing pass over all NUM_BLOCKS blocks zeroes the block memories while
// req_ready_o stays low; cfg writes are taken at any time.
// a stalled result holds in the output register and the next request is accepted.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  req_t               req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output rsp_t               rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .rsp_ready_i (rsp_ready_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .req_ready_o (req_ready_o)
  );

  ffba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (req_i),
    .rsp_ready_i (rsp_ready_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
